/* sv/swk_pkg.sv */
// Package for the sliding-window k-th smallest unit.
// Shared types and constants; no dependencies.
`default_nettype none
package swk_pkg;
  localparam int unsigned SampleW = 32;
  localparam int unsigned CfgW    = 7;
  localparam logic [CfgW-1:0] CfgRankK   = 7'd0;
  localparam logic [CfgW-1:0] CfgWinLen  = 7'd1;
  localparam logic [CfgW-1:0] RankReset  = 7'd1;
  localparam logic [CfgW-1:0] WinReset   = 7'd64;

  typedef enum logic [1:0] {
    BkIdle,
    BkScan,
    BkOut
  } bk_state_e;

  // queue entry from front to back
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               flush;
  } swk_item_t;
endpackage
`default_nettype wire

/* sv/swk_fifo.sv */
// Short queue between front and back of the k-th smallest unit.
// Depends on swk_pkg.
`default_nettype none
module swk_fifo
  import swk_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       wr_valid_i,
  output logic      wr_ready_o,
  input  swk_item_t wr_data_i,
  output logic      rd_valid_o,
  input  wire       rd_ready_i,
  output swk_item_t rd_data_o
);
  swk_item_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) cnt_d = cnt_q + 2'd1;
    else if (!wr && rd) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

/* sv/swk_front.sv */
// Front of the k-th smallest unit: takes samples and config, tags flushes.
// Depends on swk_pkg.
`default_nettype none
module swk_front
  import swk_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire  [SampleW-1:0] s_axis_tdata,
  input  wire                cfg_we_i,
  input  wire  [CfgW-1:0]    cfg_idx_i,
  output logic               q_valid_o,
  input  wire                q_ready_i,
  output swk_item_t          q_data_o
);
  logic flush_q;

  assign s_axis_tready     = q_ready_i;
  assign q_valid_o         = s_axis_tvalid;
  assign q_data_o.sample   = s_axis_tdata;
  assign q_data_o.flush    = flush_q;

  // a window_length write restarts filling at the next sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q <= 1'b0;
    end else if (cfg_we_i && cfg_idx_i == CfgWinLen) begin
      flush_q <= 1'b1;
    end else if (s_axis_tvalid && q_ready_i) begin
      flush_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* sv/swk_back.sv */
// Back of the k-th smallest unit: window store and rank-count scan.
// Depends on swk_pkg.
`default_nettype none
module swk_back
  import swk_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  output logic               q_ready_o,
  input  swk_item_t          q_data_i,
  input  wire  [CfgW-1:0]    rank_i,
  input  wire  [CfgW-1:0]    win_i,
  output logic               m_valid_o,
  input  wire                m_ready_i,
  output logic [SampleW-1:0] m_value_o,
  output logic               m_full_o
);
  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned LW = (CW > CfgW) ? CW : CfgW;

  logic [SampleW-1:0] mem_q [MAX_WINDOW];
  logic [SampleW-1:0] rd_q, cand_q, res_q;
  bk_state_e st_q, st_d;
  logic [CW-1:0] fill_q, n_c, k_c, below_q, upto_q;
  logic [AW-1:0] old_q, i_q, j_q;
  logic          full_q, rd_ph_q, res_full_q, out_v_q;
  logic [LW-1:0] win_x, rank_x;
  logic          take;
  logic [AW-1:0] wr_a;
  logic [CW-1:0] nb, nu;
  logic [SampleW-1:0] ka, kb;

  // clamp config to window range
  always_comb begin
    win_x  = LW'(win_i);
    rank_x = LW'(rank_i);
    if (win_x == '0) win_x = LW'(1);
    if (win_x > LW'(MAX_WINDOW)) win_x = LW'(MAX_WINDOW);
    n_c = CW'(win_x);
    if (rank_x == '0) rank_x = LW'(1);
    if (rank_x > win_x) rank_x = win_x;
    k_c = CW'(rank_x);
  end

  assign q_ready_o = (st_q == BkIdle) && !out_v_q;
  assign take      = q_valid_i && q_ready_o;
  assign m_valid_o = out_v_q;
  assign m_value_o = res_q;
  assign m_full_o  = res_full_q;

  logic [CW-1:0] fill_e;
  logic [AW-1:0] old_e;
  always_comb begin
    fill_e = q_data_i.flush ? '0 : fill_q;
    old_e  = q_data_i.flush ? '0 : old_q;
    if (CW'(old_e) >= n_c) old_e = '0;
    wr_a = (fill_e < n_c) ? fill_e[AW-1:0] : old_e;
  end

  assign ka = cand_q ^ {1'b1, {(SampleW-1){1'b0}}};
  assign kb = rd_q   ^ {1'b1, {(SampleW-1){1'b0}}};
  assign nb = below_q + CW'(kb < ka);
  assign nu = upto_q  + CW'(kb <= ka);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BkIdle: if (take) st_d = full_q ? BkIdle : BkIdle;
      BkScan: if (rd_ph_q && CW'(j_q) == n_c - CW'(1) &&
                  ((nb < k_c && k_c <= nu) || CW'(i_q) == n_c - CW'(1))) st_d = BkOut;
      BkOut:  st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
    if (st_q == BkIdle && take) begin
      st_d = ((fill_e + CW'(fill_e < n_c)) >= n_c) ? BkScan : BkOut;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle; fill_q <= '0; old_q <= '0; out_v_q <= 1'b0;
      i_q <= '0; j_q <= '0; rd_ph_q <= 1'b0; full_q <= 1'b0;
      below_q <= '0; upto_q <= '0; res_full_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_v_q && m_ready_i) out_v_q <= 1'b0;
      if (take) begin
        if (fill_e < n_c) begin
          fill_q <= fill_e + CW'(1); old_q <= '0;
        end else begin
          fill_q <= fill_e;
          old_q  <= (CW'(old_e) + CW'(1) >= n_c) ? '0 : old_e + AW'(1);
        end
        full_q <= (fill_e + CW'(fill_e < n_c)) >= n_c;
        i_q <= '0; j_q <= '0; rd_ph_q <= 1'b0;
        below_q <= '0; upto_q <= '0;
      end
      if (st_q == BkScan) begin
        // two-phase: read cand then count over j, one compare per cycle
        if (!rd_ph_q) begin
          rd_ph_q <= 1'b1;
        end else begin
          if (CW'(j_q) == n_c - CW'(1)) begin
            j_q <= '0; below_q <= '0; upto_q <= '0; rd_ph_q <= 1'b0;
            i_q <= i_q + AW'(1);
            if (st_d == BkOut) begin
              res_q <= (nb < k_c && k_c <= nu) ? cand_q : '0;
              res_full_q <= 1'b1;
            end
          end else begin
            j_q <= j_q + AW'(1); below_q <= nb; upto_q <= nu;
          end
        end
      end
      if (st_q == BkIdle && take && st_d == BkOut) begin
        res_q <= '0; res_full_q <= 1'b0;
      end
      if (st_q == BkOut) out_v_q <= 1'b1;
    end
  end

  // memory: one write port, two read ports (rd_q, cand_q); cand loaded on first phase
  logic [AW-1:0] ra;
  assign ra = (st_q == BkScan && !rd_ph_q) ? '0 :
              (rd_ph_q && CW'(j_q) != n_c - CW'(1)) ? j_q + AW'(1) : '0;
  logic ld_c;
  assign ld_c = (st_q == BkScan && !rd_ph_q);
  always_ff @(posedge clk_i) begin
    if (take) mem_q[wr_a] <= q_data_i.sample;
    rd_q   <= mem_q[ra];
  end
  // rd_q after cand phase holds mem[0]; first compare is j=0
  always_ff @(posedge clk_i) begin
    if (ld_c) cand_q <= mem_q[i_q];
  end
endmodule
`default_nettype wire

/* sv/sliding_window_kth_smallest_unit.sv */
// Top level of the sliding-window k-th smallest (rank order) filter.
// Depends on swk_pkg, swk_front, swk_fifo, swk_back.
//
// Usage:
//   s_axis_* carries one signed 32-bit sample per transaction (tdata[31:0]).
//   m_axis_* returns one result per sample: tdata[31:0] = kth_value,
//   tuser[0] = window_full. kth_value is 0 until the window has filled.
//   cfg_we_i/cfg_idx_i/cfg_data_i write rank_k (index 0) or window_length
//   (index 1); a window_length write flushes the window. Write only when idle.
// Scan: once the window is full, the back end ranks each stored sample
//   against the window, one compare per cycle through the rd_q read port
//   of the sample memory; the scan stops at the first stored sample whose
//   rank range covers rank_k. The back end takes no new sample until its
//   result has been taken.
// Path to a result: the queue, then state BkOut while filling, or BkScan
//   and then BkOut once full; the result valid is registered after BkOut.
// A two-entry queue decouples the input from the back end.
// Reset: rank_k = 1, window_length = 64, window empty; memory not cleared.
// Stall: when m_axis_tready is low the result holds and the back end waits;
//   the queue still takes up to two more samples.
`default_nettype none
module sliding_window_kth_smallest_unit
  import swk_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] sample
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] kth_value
  output logic [0:0]  m_axis_tuser,   // [0] window_full
  input  wire         cfg_we_i,
  input  wire  [6:0]  cfg_idx_i,
  input  wire  [6:0]  cfg_data_i
);
  logic [CfgW-1:0] rank_q, win_q;
  swk_item_t f_data, b_data;
  logic f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RankReset;
      win_q  <= WinReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgRankK)  rank_q <= cfg_data_i;
      if (cfg_idx_i == CfgWinLen) win_q  <= cfg_data_i;
    end
  end

  swk_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cfg_we_i, .cfg_idx_i,
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_data_o(f_data)
  );

  swk_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_data),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_data)
  );

  swk_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_data_i(b_data),
    .rank_i(rank_q), .win_i(win_q),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_value_o(m_axis_tdata), .m_full_o(m_axis_tuser[0])
  );
endmodule
`default_nettype wire
